[rtl/swk_pkg.sv]
// Shared types, widths and helpers for the sliding-window kurtosis block.
// Used by swk_ctrl, swk_dpath and sliding_window_kurtosis; depends on nothing.
package swk_pkg;

  localparam int SAMPLE_BITS = 14;
  localparam int RING_DEPTH  = 256;
  localparam int PTR_BITS    = 8;
  localparam int WIN_BITS    = 9;
  localparam int MAG_BITS    = 14;
  localparam int SQ_BITS     = 2 * MAG_BITS - 1;
  localparam int P4_BITS     = 2 * SQ_BITS - 1;
  localparam int S2_BITS     = SQ_BITS + PTR_BITS;
  localparam int S4_BITS     = P4_BITS + PTR_BITS;
  localparam int S2_LO_BITS  = 18;
  localparam int S2_HI_BITS  = S2_BITS - S2_LO_BITS;
  localparam int S4_LO_BITS  = 31;
  localparam int S4_HI_BITS  = S4_BITS - S4_LO_BITS;
  localparam int MUL_BITS    = 32;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int FRAC_BITS   = 8;
  localparam int Q_BITS      = 17;
  localparam int CNT_BITS    = 5;
  localparam int DEN_BITS    = 2 * S2_BITS - 1;
  localparam int NUM_BITS    = S4_BITS + WIN_BITS - 1;
  localparam int REM_BITS    = NUM_BITS + FRAC_BITS;
  localparam int DIV_BITS    = DEN_BITS + Q_BITS - 1;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 2;

  localparam logic [WIN_BITS-1:0] WIN_MIN   = WIN_BITS'(2);
  localparam logic [WIN_BITS-1:0] WIN_MAX   = WIN_BITS'(RING_DEPTH);
  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(64);
  localparam logic [Q_BITS-1:0]   Q_MAX     = Q_BITS'(65536);

  // Datapath operations, one per controller step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SQ_NEW,
    OP_P4_NEW,
    OP_SQ_OLD,
    OP_P4_OLD,
    OP_SUB4,
    OP_D_LL,
    OP_D_LH,
    OP_D_HH,
    OP_N_LO,
    OP_N_HI,
    OP_N_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic s2_zero;
    logic out_free;
  } dp_status_t;

  // Magnitude of a two's complement sample; the most negative code gives 2^13.
  function automatic logic [MAG_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS:0] t;
    if (raw[SAMPLE_BITS-1]) begin
      t = (SAMPLE_BITS + 1)'(1) << SAMPLE_BITS;
      t = t - {1'b0, raw};
    end else begin
      t = {1'b0, raw};
    end
    return t[MAG_BITS-1:0];
  endfunction

endpackage

[rtl/sliding_window_kurtosis.sv]
// Top level of the sliding-window kurtosis block: configuration register,
// sequencer and datapath. Depends on swk_pkg, swk_ctrl and swk_dpath.
//
// Usage: each request on the input channel (in_valid/in_ready) carries one
// signed 14-bit sample and an end_of_trace mark. Every request yields exactly
// one result on the output channel (out_valid/out_ready): the kurtosis
// N*S4/S2^2 of the last N samples in unsigned Q9.8, with window_full and
// zero_energy flags. Until N samples of a trace have gone before, the value
// is zero. The window clears when the result for a marked sample is loaded.
// While the window fills or has no energy, a request skips the multiply steps
// on the shared 32x32 multiplier and the 17-step restoring divider. One
// request is worked on at a time; in_ready rises again together with out_valid
// when the result is loaded, so a new request is taken while that result
// still waits. If the receiver stalls, the next result waits in its last step
// until the output register is taken. Reset sets window_length to 64 and
// clears the trace state; the sample ring needs no clearing. A write to
// window_length (APB, byte address 0) also clears the trace state; write
// only while idle.
module sliding_window_kurtosis (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [swk_pkg::APB_ADDR_BITS-1:0]       paddr,
  input  logic [swk_pkg::APB_DATA_BITS-1:0]       pwdata,
  output logic [swk_pkg::APB_DATA_BITS-1:0]       prdata,
  output logic                                    pready,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [swk_pkg::SAMPLE_BITS-1:0]  sample,
  input  logic                                    end_of_trace,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [swk_pkg::Q_BITS-1:0]              kurtosis_value,
  output logic                                    window_full,
  output logic                                    zero_energy
);

  logic [swk_pkg::WIN_BITS-1:0] window_length;
  logic [swk_pkg::WIN_BITS-1:0] win_n;
  logic                         cfg_write;
  swk_pkg::dp_cmd_t             cmd;
  swk_pkg::dp_status_t          status;

  // The only register occupies the whole address space.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = swk_pkg::APB_DATA_BITS'(window_length) |
                     swk_pkg::APB_DATA_BITS'(paddr & 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swk_pkg::WIN_RESET;
    end else if (cfg_write) begin
      window_length <= pwdata[swk_pkg::WIN_BITS-1:0];
    end
  end

  // Out-of-range window lengths act as the nearest legal size.
  always_comb begin
    if (window_length < swk_pkg::WIN_MIN) begin
      win_n = swk_pkg::WIN_MIN;
    end else if (window_length > swk_pkg::WIN_MAX) begin
      win_n = swk_pkg::WIN_MAX;
    end else begin
      win_n = window_length;
    end
  end

  swk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  swk_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .win_n          (win_n),
    .cfg_write      (cfg_write),
    .sample         (sample),
    .end_of_trace   (end_of_trace),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kurtosis_value (kurtosis_value),
    .window_full    (window_full),
    .zero_energy    (zero_energy)
  );

endmodule

[rtl/swk_ctrl.sv]
// Sequencer for the kurtosis datapath: one step per state, 17-step divide loop.
// Depends on swk_pkg for the command and status types.
module swk_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  swk_pkg::dp_status_t   status,
  output swk_pkg::dp_cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ_NEW,
    S_P4_NEW,
    S_SQ_OLD,
    S_P4_OLD,
    S_SUB4,
    S_CHECK,
    S_D_LL,
    S_D_LH,
    S_D_HH,
    S_N_LO,
    S_N_HI,
    S_N_ADD,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic [swk_pkg::CNT_BITS-1:0] step_cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = swk_pkg::OP_NONE;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = swk_pkg::OP_ACCEPT;
          state_next = S_SQ_NEW;
        end
      end
      S_SQ_NEW: begin
        cmd.op     = swk_pkg::OP_SQ_NEW;
        state_next = S_P4_NEW;
      end
      S_P4_NEW: begin
        cmd.op     = swk_pkg::OP_P4_NEW;
        state_next = S_SQ_OLD;
      end
      S_SQ_OLD: begin
        cmd.op     = swk_pkg::OP_SQ_OLD;
        state_next = S_P4_OLD;
      end
      S_P4_OLD: begin
        cmd.op     = swk_pkg::OP_P4_OLD;
        state_next = S_SUB4;
      end
      S_SUB4: begin
        cmd.op     = swk_pkg::OP_SUB4;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        // Only a full window with energy needs the quotient.
        if (status.full && !status.s2_zero) begin
          state_next = S_D_LL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_D_LL: begin
        cmd.op     = swk_pkg::OP_D_LL;
        state_next = S_D_LH;
      end
      S_D_LH: begin
        cmd.op     = swk_pkg::OP_D_LH;
        state_next = S_D_HH;
      end
      S_D_HH: begin
        cmd.op     = swk_pkg::OP_D_HH;
        state_next = S_N_LO;
      end
      S_N_LO: begin
        cmd.op     = swk_pkg::OP_N_LO;
        state_next = S_N_HI;
      end
      S_N_HI: begin
        cmd.op     = swk_pkg::OP_N_HI;
        state_next = S_N_ADD;
      end
      S_N_ADD: begin
        cmd.op     = swk_pkg::OP_N_ADD;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op     = swk_pkg::OP_DIV_INIT;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op = swk_pkg::OP_DIV_STEP;
        if (step_cnt == swk_pkg::CNT_BITS'(swk_pkg::Q_BITS - 1)) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op     = swk_pkg::OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV_INIT) begin
        step_cnt <= '0;
      end else if (state == S_DIV) begin
        step_cnt <= step_cnt + 1'b1;
      end
    end
  end

endmodule

[rtl/swk_dpath.sv]
// Datapath: sample ring, running sums, shared 32x32 multiplier, restoring divider
// and the result register. Depends on swk_pkg; driven by swk_ctrl.
module swk_dpath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  swk_pkg::dp_cmd_t                      cmd,
  output swk_pkg::dp_status_t                   status,
  input  logic [swk_pkg::WIN_BITS-1:0]          win_n,
  input  logic                                  cfg_write,
  input  logic signed [swk_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                  end_of_trace,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [swk_pkg::Q_BITS-1:0]            kurtosis_value,
  output logic                                  window_full,
  output logic                                  zero_energy
);

  logic [swk_pkg::SAMPLE_BITS-1:0] ring [swk_pkg::RING_DEPTH];

  logic [swk_pkg::PTR_BITS-1:0]    ptr;
  logic [swk_pkg::WIN_BITS-1:0]    seen;
  logic [swk_pkg::S2_BITS-1:0]     s2;
  logic [swk_pkg::S4_BITS-1:0]     s4;
  logic [swk_pkg::SAMPLE_BITS-1:0] new_raw;
  logic [swk_pkg::SAMPLE_BITS-1:0] old_raw;
  logic                            eot;
  logic                            full;
  logic [swk_pkg::PROD_BITS-1:0]   p;
  logic [swk_pkg::DEN_BITS-1:0]    den;
  logic [swk_pkg::NUM_BITS-1:0]    num;
  logic [swk_pkg::REM_BITS-1:0]    rem;
  logic [swk_pkg::DIV_BITS-1:0]    dv;
  logic [swk_pkg::Q_BITS-1:0]      q;

  logic [swk_pkg::PTR_BITS-1:0]    rd_addr;
  logic [swk_pkg::MAG_BITS-1:0]    mag_new;
  logic [swk_pkg::MAG_BITS-1:0]    mag_old;
  logic [swk_pkg::MUL_BITS-1:0]    mul_a;
  logic [swk_pkg::MUL_BITS-1:0]    mul_b;
  logic [swk_pkg::PROD_BITS-1:0]   prod;
  logic                            mul_en;
  logic                            s2_zero;
  logic                            fits;
  logic                            clear_trace;

  // The oldest sample sits N places behind the write pointer, modulo the ring.
  assign rd_addr = ptr - win_n[swk_pkg::PTR_BITS-1:0];
  assign mag_new = swk_pkg::magnitude(new_raw);
  assign mag_old = swk_pkg::magnitude(old_raw);
  assign s2_zero = (s2 == '0);
  assign fits    = (swk_pkg::DIV_BITS'(rem) >= dv);
  assign prod    = mul_a * mul_b;

  assign clear_trace = cfg_write || ((cmd.op == swk_pkg::OP_FINISH) && eot);

  assign status.full     = full;
  assign status.s2_zero  = s2_zero;
  assign status.out_free = !out_valid || out_ready;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      swk_pkg::OP_SQ_NEW: begin
        mul_a = swk_pkg::MUL_BITS'(mag_new);
        mul_b = swk_pkg::MUL_BITS'(mag_new);
      end
      swk_pkg::OP_P4_NEW, swk_pkg::OP_P4_OLD: begin
        mul_a = swk_pkg::MUL_BITS'(p[swk_pkg::SQ_BITS-1:0]);
        mul_b = swk_pkg::MUL_BITS'(p[swk_pkg::SQ_BITS-1:0]);
      end
      swk_pkg::OP_SQ_OLD: begin
        mul_a = swk_pkg::MUL_BITS'(mag_old);
        mul_b = swk_pkg::MUL_BITS'(mag_old);
      end
      swk_pkg::OP_D_LL: begin
        mul_a = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_LO_BITS-1:0]);
        mul_b = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_LO_BITS-1:0]);
      end
      swk_pkg::OP_D_LH: begin
        mul_a = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_LO_BITS-1:0]);
        mul_b = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_BITS-1:swk_pkg::S2_LO_BITS]);
      end
      swk_pkg::OP_D_HH: begin
        mul_a = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_BITS-1:swk_pkg::S2_LO_BITS]);
        mul_b = swk_pkg::MUL_BITS'(s2[swk_pkg::S2_BITS-1:swk_pkg::S2_LO_BITS]);
      end
      swk_pkg::OP_N_LO: begin
        mul_a = swk_pkg::MUL_BITS'(s4[swk_pkg::S4_LO_BITS-1:0]);
        mul_b = swk_pkg::MUL_BITS'(win_n);
      end
      swk_pkg::OP_N_HI: begin
        mul_a = swk_pkg::MUL_BITS'(s4[swk_pkg::S4_BITS-1:swk_pkg::S4_LO_BITS]);
        mul_b = swk_pkg::MUL_BITS'(win_n);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Trace state and the result handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      seen      <= '0;
      s2        <= '0;
      s4        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == swk_pkg::OP_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (clear_trace) begin
        ptr  <= '0;
        seen <= '0;
        s2   <= '0;
        s4   <= '0;
      end else begin
        case (cmd.op)
          swk_pkg::OP_ACCEPT: begin
            ptr <= ptr + 1'b1;
            if (seen < win_n) begin
              seen <= seen + 1'b1;
            end
          end
          swk_pkg::OP_P4_NEW: begin
            s2 <= s2 + swk_pkg::S2_BITS'(p[swk_pkg::SQ_BITS-1:0]);
          end
          swk_pkg::OP_SQ_OLD: begin
            s4 <= s4 + swk_pkg::S4_BITS'(p[swk_pkg::P4_BITS-1:0]);
          end
          swk_pkg::OP_P4_OLD: begin
            if (full) begin
              s2 <= s2 - swk_pkg::S2_BITS'(p[swk_pkg::SQ_BITS-1:0]);
            end
          end
          swk_pkg::OP_SUB4: begin
            if (full) begin
              s4 <= s4 - swk_pkg::S4_BITS'(p[swk_pkg::P4_BITS-1:0]);
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Ring, operand and arithmetic registers.
  always_ff @(posedge clk) begin
    if (mul_en) begin
      p <= prod;
    end
    case (cmd.op)
      swk_pkg::OP_ACCEPT: begin
        // The read sees the entry before this write, which matters when N fills the ring.
        ring[ptr] <= sample;
        old_raw   <= ring[rd_addr];
        new_raw   <= sample;
        eot       <= end_of_trace;
        full      <= (seen >= win_n);
      end
      swk_pkg::OP_D_LH: begin
        den <= swk_pkg::DEN_BITS'(p);
      end
      swk_pkg::OP_D_HH: begin
        den <= den + (swk_pkg::DEN_BITS'(p) << (swk_pkg::S2_LO_BITS + 1));
      end
      swk_pkg::OP_N_LO: begin
        den <= den + (swk_pkg::DEN_BITS'(p) << (2 * swk_pkg::S2_LO_BITS));
      end
      swk_pkg::OP_N_HI: begin
        num <= swk_pkg::NUM_BITS'(p);
      end
      swk_pkg::OP_N_ADD: begin
        num <= num + (swk_pkg::NUM_BITS'(p) << swk_pkg::S4_LO_BITS);
      end
      swk_pkg::OP_DIV_INIT: begin
        rem <= swk_pkg::REM_BITS'(num) << swk_pkg::FRAC_BITS;
        dv  <= swk_pkg::DIV_BITS'(den) << (swk_pkg::Q_BITS - 1);
        q   <= '0;
      end
      swk_pkg::OP_DIV_STEP: begin
        if (fits) begin
          rem <= rem - dv[swk_pkg::REM_BITS-1:0];
        end
        q  <= {q[swk_pkg::Q_BITS-2:0], fits};
        dv <= dv >> 1;
      end
      swk_pkg::OP_FINISH: begin
        window_full <= full;
        zero_energy <= full && s2_zero;
        if (full && !s2_zero) begin
          kurtosis_value <= (q > swk_pkg::Q_MAX) ? swk_pkg::Q_MAX : q;
        end else begin
          kurtosis_value <= '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/tb_sliding_window_kurtosis.sv]
// Self-checking testbench for sliding_window_kurtosis: directed and random sample
// streams over several window lengths, checked against an in-bench kurtosis tracker.
// Depends on swk_pkg and the sliding_window_kurtosis RTL.
`timescale 1ns / 1ps

module tb_sliding_window_kurtosis;

  localparam int SAMPLE_BITS   = swk_pkg::SAMPLE_BITS;
  localparam int RING_DEPTH    = swk_pkg::RING_DEPTH;
  localparam int WIN_BITS      = swk_pkg::WIN_BITS;
  localparam int Q_BITS        = swk_pkg::Q_BITS;
  localparam int APB_ADDR_BITS = swk_pkg::APB_ADDR_BITS;
  localparam int APB_DATA_BITS = swk_pkg::APB_DATA_BITS;

  localparam logic [APB_ADDR_BITS-1:0] REG_WINDOW_LENGTH = APB_ADDR_BITS'(0);
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CEILING        = 65536;

  typedef struct packed {
    logic [Q_BITS-1:0] value;
    logic              full;
    logic              no_energy;
  } kurt_result_t;

  // Tracks the window state and holds the results still owed by the block.
  class kurtosis_tracker;
    logic [WIN_BITS-1:0]    window_reg;
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    int unsigned            ptr;
    int unsigned            seen;
    logic [63:0]            s2;
    logic [63:0]            s4;
    kurt_result_t           pending_kurtosis [$];
    int                     errors;
    int                     results;
    int                     full_seen;
    int                     dead_seen;
    int                     ceiling_seen;

    function new();
      window_reg   = WIN_BITS'(64);
      errors       = 0;
      results      = 0;
      full_seen    = 0;
      dead_seen    = 0;
      ceiling_seen = 0;
      clear_trace();
    endfunction

    function void clear_trace();
      ptr  = 0;
      seen = 0;
      s2   = '0;
      s4   = '0;
    endfunction

    function void set_window(logic [APB_DATA_BITS-1:0] word);
      window_reg = word[WIN_BITS-1:0];
      clear_trace();
    endfunction

    function int unsigned window_size();
      if (window_reg < 2) return 2;
      if (window_reg > RING_DEPTH) return RING_DEPTH;
      return window_reg;
    endfunction

    function logic [63:0] abs_sample(logic [SAMPLE_BITS-1:0] raw);
      if (raw[SAMPLE_BITS-1]) return 64'(1 << SAMPLE_BITS) - 64'(raw);
      return 64'(raw);
    endfunction

    function int outstanding();
      return pending_kurtosis.size();
    endfunction

    // Updates the window with an accepted request and queues its kurtosis.
    function void take_sample(logic [SAMPLE_BITS-1:0] raw, logic last);
      int unsigned  n;
      int unsigned  idx;
      logic [63:0]  mag;
      logic [63:0]  sq;
      logic [63:0]  old_sq;
      logic [127:0] num;
      logic [127:0] den;
      int unsigned  quot;
      int unsigned  trial;
      kurt_result_t res;
      n   = window_size();
      mag = abs_sample(raw);
      sq  = mag * mag;
      res = '0;
      res.full = (seen >= n);
      if (res.full) begin
        idx    = (ptr + RING_DEPTH - n) % RING_DEPTH;
        old_sq = abs_sample(ring[idx]) * abs_sample(ring[idx]);
        s2     = s2 - old_sq;
        s4     = s4 - old_sq * old_sq;
      end
      ring[ptr] = raw;
      ptr       = (ptr + 1) % RING_DEPTH;
      s2        = s2 + sq;
      s4        = s4 + sq * sq;
      if (seen < n) seen++;
      if (res.full) begin
        if (s2 == 0) begin
          res.no_energy = 1'b1;
        end else begin
          num  = 128'(s4) * 128'(n) * 128'(256);
          den  = 128'(s2) * 128'(s2);
          quot = 0;
          for (int b = Q_BITS - 1; b >= 0; b--) begin
            trial = quot | (32'd1 << b);
            if (den * 128'(trial) <= num) quot = trial;
          end
          if (quot > CEILING) quot = CEILING;
          res.value = Q_BITS'(quot);
        end
      end
      pending_kurtosis.push_back(res);
      if (last) clear_trace();
    endfunction

    function void match_result(logic [Q_BITS-1:0] value, logic full, logic no_energy);
      kurt_result_t want;
      if (pending_kurtosis.size() == 0) begin
        $display("%0t: result with no request outstanding: value %0d full %0b zero %0b",
                 $time, value, full, no_energy);
        errors++;
        return;
      end
      want = pending_kurtosis.pop_front();
      results++;
      if (want.full) full_seen++;
      if (want.no_energy) dead_seen++;
      if (want.value == CEILING) ceiling_seen++;
      if (value !== want.value) begin
        $display("%0t: kurtosis_value expected %0d, got %0d", $time, want.value, value);
        errors++;
      end
      if (full !== want.full) begin
        $display("%0t: window_full expected %0b, got %0b", $time, want.full, full);
        errors++;
      end
      if (no_energy !== want.no_energy) begin
        $display("%0t: zero_energy expected %0b, got %0b", $time, want.no_energy, no_energy);
        errors++;
      end
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [APB_ADDR_BITS-1:0]        paddr;
  logic [APB_DATA_BITS-1:0]        pwdata;
  logic [APB_DATA_BITS-1:0]        prdata;
  logic                            pready;
  logic                            in_valid;
  logic                            in_ready;
  logic signed [SAMPLE_BITS-1:0]   sample;
  logic                            end_of_trace;
  logic                            out_valid;
  logic                            out_ready;
  logic [Q_BITS-1:0]               kurtosis_value;
  logic                            window_full;
  logic                            zero_energy;

  kurtosis_tracker tracker = new();
  bit              steady;
  int              idle_cycles;
  int              settings_used;

  sliding_window_kurtosis uut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .sample         (sample),
    .end_of_trace   (end_of_trace),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kurtosis_value (kurtosis_value),
    .window_full    (window_full),
    .zero_energy    (zero_energy)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 34);
  endfunction

  // Receiver: checks every accepted result and stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        tracker.match_result(kurtosis_value, window_full, zero_energy);
      out_ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, tracker.outstanding());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Presents one request and returns at the edge where it is accepted.
  // The valid is left high so that a following request can go out back to back.
  task automatic send_sample(input int value, input bit last);
    int gap;
    gap = 0;
    while (take_break()) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample       <= SAMPLE_BITS'(value);
    end_of_trace <= last;
    do @(posedge clk); while (!in_ready);
    tracker.take_sample(SAMPLE_BITS'(value), last);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DATA_BITS-1:0] wdata,
                            output logic [APB_DATA_BITS-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_WINDOW_LENGTH;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_window_reg(input logic [WIN_BITS-1:0] want);
    logic [APB_DATA_BITS-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata !== APB_DATA_BITS'(want)) begin
      $display("%0t: window_length read expected %0d, got %0d", $time, want, rdata);
      tracker.errors++;
    end
  endtask

  // Writes window_length once the block has drained, then reads it back.
  task automatic program_window(input int win);
    logic [APB_DATA_BITS-1:0] word;
    logic [APB_DATA_BITS-1:0] rdata;
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    word = ($urandom() << WIN_BITS) | APB_DATA_BITS'(win);
    apb_access(1'b1, word, rdata);
    tracker.set_window(word);
    settings_used++;
    check_window_reg(word[WIN_BITS-1:0]);
  endtask

  function automatic int pick_sample(bit quiet);
    int roll;
    roll = $urandom_range(99);
    if (quiet) begin
      if (roll != 0) return 0;
      roll = $urandom_range(99);
    end
    if (roll < 40) return $signed(SAMPLE_BITS'($urandom()));
    if (roll < 60) return $urandom_range(30) - 15;
    if (roll < 75) begin
      case ($urandom_range(4))
        0: return -8192;
        1: return 8191;
        2: return -1;
        3: return 1;
        default: return 0;
      endcase
    end
    if (roll < 85) return 0;
    return $urandom_range(2000) - 1000;
  endfunction

  initial begin
    int phase_win   [9];
    int phase_items [9];
    int phase_eot   [9];
    bit phase_quiet [9];
    bit phase_calm  [9];
    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid     = 1'b0;
    sample       = '0;
    end_of_trace = 1'b0;
    steady       = 1'b0;
    settings_used = 1;
    phase_win   = '{2,  3,  257, 17, 256, 64, 511, 5,  0};
    phase_items = '{30, 50, 262, 30, 20,  30, 20,  30, 30};
    phase_eot   = '{30, 20, 0,   30, 0,   20, 0,   100, 40};
    phase_quiet = '{0,  0,  1,   0,  0,   0,  0,   0,  0};
    phase_calm  = '{0,  1,  0,   0,  0,   0,  0,   0,  0};
    phase_win[8] = $urandom_range(40, 2);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The register must come out of reset at 64.
    check_window_reg(WIN_BITS'(64));

    // Directed: extremes while the reset window is still filling.
    send_sample(-8192, 1'b0);
    send_sample(8191, 1'b0);
    send_sample(0, 1'b1);

    // A length of zero acts as two: silent window, a lone extreme, then a restart.
    program_window(0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-8192, 1'b0);
    send_sample(8191, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(1, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);

    program_window(1);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b0);
    send_sample(7, 1'b1);

    program_window(3);
    repeat (3) send_sample(-8192, 1'b0);
    send_sample(-8192, 1'b1);

    // Random phases; one long-window phase is kept mostly silent so that lone
    // spikes drive the result up to its ceiling.
    for (int p = 0; p < 9; p++) begin
      program_window(phase_win[p]);
      steady = phase_calm[p];
      for (int i = 0; i < phase_items[p]; i++)
        send_sample(pick_sample(phase_quiet[p]), $urandom_range(999) < phase_eot[p]);
      steady = 1'b0;
    end

    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d window settings: %0d with a full window,",
             tracker.results, settings_used, tracker.full_seen);
    $display("%0d with no energy in the window and %0d at the ceiling of the range.",
             tracker.dead_seen, tracker.ceiling_seen);
    if (tracker.outstanding() != 0)
      $display("%0t: %0d requests never produced a result", $time, tracker.outstanding());
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
